>>> hdl/sobm_pkg.sv
package sobm_pkg;

    // Line store depth, largest supported frame width
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // Register and counter widths
    localparam int FW_W  = 12;
    localparam int FH_W  = 16;
    localparam int ROW_W = 17;
    localparam int EW_W  = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;

    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] FW_RESET = 12'd640;
    localparam logic [FH_W-1:0] FH_RESET = 16'd480;

    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    localparam int FIFO_DEPTH = 4;

    typedef logic [PIX_W-1:0] t_pix;

    // One classified window on its way to the gradient datapath.
    // px[k*3+j]: row k (0 = top), column j (0 = left), padding already zeroed.
    typedef struct packed {
        t_pix [8:0] px;
        logic       last;
    } t_win_item;

endpackage

>>> hdl/sobel_edge_magnitude_rgb_unit.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_kind, i_red_in, i_green_in, i_blue_in
// output    o_out_valid / i_out_ready  o_red_out, o_green_out, o_blue_out, o_frame_last
// config    i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// Takes one pixel per clock while the queue is not full; the line store has one read
// and one write port, and the read result is ready in the cycle after acceptance.
// A result follows the accepting of the pixel W+1 raster positions later: it passes
// the front register, the queue, then the gradient / square-root pipeline
// registers loaded from the queue.
// Reset (synchronous, active low) empties both halves; line stores need no
// clearing pass since rows above the frame are masked as padding.
// Output stalls fill the 4-entry queue before the input side stalls.
module sobel_edge_magnitude_rgb_unit
    import sobm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [CH_W-1:0]       i_red_in,
    input  logic [CH_W-1:0]       i_green_in,
    input  logic [CH_W-1:0]       i_blue_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CH_W-1:0]       o_red_out,
    output logic [CH_W-1:0]       o_green_out,
    output logic [CH_W-1:0]       o_blue_out,
    output logic                  o_frame_last
);

    // front: raster position, padding masks, line store, 3x3 window
    t_win_item push_item;
    t_win_item pop_item;
    logic      push;
    logic      pop;
    logic      fifo_full;
    logic      fifo_empty;

    sobm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_push      (push),
        .o_push_item (push_item),
        .i_fifo_full (fifo_full)
    );

    // only windows that produce a result enter the queue
    sobm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    // back: Gx/Gy, squared sum, two-stage square root, rounding and clamp
    sobm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (fifo_empty),
        .i_item       (pop_item),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_frame_last (o_frame_last)
    );

endmodule

>>> hdl/sobm_ram.sv
module sobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sobm_front.sv
module sobm_front
    import sobm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [CH_W-1:0]       i_red_in,
    input  logic [CH_W-1:0]       i_green_in,
    input  logic [CH_W-1:0]       i_blue_in,
    output logic                  o_push,
    output t_win_item             o_push_item,
    input  logic                  i_fifo_full
);

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic [EW_W-1:0]  eff_w;
    logic [ROW_W-1:0] eff_h;
    logic [COL_W-1:0] cur_col;
    logic             is_c0;
    logic             emit;
    logic [ROW_W-1:0] rc;
    logic [COL_W-1:0] cc;
    logic [3:0]       mask;       // top, bottom, left, right
    logic             last;
    t_pix             pix;
    logic [EW_W-1:0]  col_inc;
    logic             accept;

    // item held while the line store read completes
    logic             r_f1_valid;
    logic [COL_W-1:0] r_f1_col;
    t_pix             r_f1_pix;
    logic             r_f1_c0;
    logic             r_f1_emit;
    logic [3:0]       r_f1_mask;
    logic             r_f1_last;
    logic             r_fwd;
    t_pix             r_fwd_up;
    t_pix             r_fwd_mid;
    logic             f1_adv;

    logic [2*PIX_W-1:0] ram_rdata;
    t_pix               line_top;
    t_pix               line_mid;
    t_pix               r_w1 [3];
    t_pix               r_w2 [3];
    t_pix               new_col [3];

    always_comb begin
        eff_w = EW_W'(r_frame_width);
        if (eff_w == '0) begin
            eff_w = EW_W'(1);
        end else if (eff_w > EW_W'(MAX_WIDTH)) begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        eff_h = (r_frame_height == '0) ? ROW_W'(1) : ROW_W'(r_frame_height);
    end

    always_comb begin
        cur_col = (EW_W'(r_col) >= eff_w) ? '0 : r_col;
        is_c0   = (cur_col == '0);
        if (is_c0) begin
            // row start closes the previous row's last column
            emit = (r_row >= ROW_W'(2)) && ((r_row - ROW_W'(2)) < eff_h);
            rc   = r_row - ROW_W'(2);
            cc   = COL_W'(eff_w - EW_W'(1));
        end else begin
            emit = (r_row >= ROW_W'(1)) && ((r_row - ROW_W'(1)) < eff_h);
            rc   = r_row - ROW_W'(1);
            cc   = cur_col - COL_W'(1);
        end
        mask[3] = (rc != '0);
        mask[2] = ((ROW_W + 1)'(rc) + (ROW_W + 1)'(1)) < (ROW_W + 1)'(eff_h);
        mask[1] = (cc != '0);
        mask[0] = (EW_W'(cc) + EW_W'(1)) < eff_w;
        last    = emit && (rc == eff_h - ROW_W'(1)) && (EW_W'(cc) == eff_w - EW_W'(1));
        pix     = (i_kind || (r_row >= eff_h)) ? '0 : {i_red_in, i_green_in, i_blue_in};
        col_inc = EW_W'(cur_col) + EW_W'(1);
        if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= eff_w) begin
            n_col = '0;
            n_row = (r_row == ROW_MAX) ? r_row : r_row + ROW_W'(1);
        end else begin
            n_col = col_inc[COL_W-1:0];
            n_row = r_row;
        end
    end

    assign f1_adv     = r_f1_valid && (!r_f1_emit || !i_fifo_full);
    assign o_in_ready = !r_f1_valid || f1_adv;
    assign accept     = i_in_valid && o_in_ready;

    // upper and middle lines share one word: {upper, middle}
    sobm_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (f1_adv),
        .i_waddr (r_f1_col),
        .i_wdata ({line_mid, r_f1_pix}),
        .i_re    (accept),
        .i_raddr (cur_col),
        .o_rdata (ram_rdata)
    );

    // one-column frames hit the same address back to back
    assign line_top = r_fwd ? r_fwd_up  : ram_rdata[2*PIX_W-1:PIX_W];
    assign line_mid = r_fwd ? r_fwd_mid : ram_rdata[PIX_W-1:0];

    assign new_col[0] = line_top;
    assign new_col[1] = line_mid;
    assign new_col[2] = r_f1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_f1_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH: begin
                        r_frame_width <= i_cfg_data[FW_W-1:0];
                        r_col         <= '0;
                        r_row         <= '0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        r_frame_height <= i_cfg_data[FH_W-1:0];
                        r_col          <= '0;
                        r_row          <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_f1_valid <= 1'b1;
            end else if (f1_adv) begin
                r_f1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_col  <= cur_col;
            r_f1_pix  <= pix;
            r_f1_c0   <= is_c0;
            r_f1_emit <= emit;
            r_f1_mask <= mask;
            r_f1_last <= last;
            r_fwd     <= f1_adv && (r_f1_col == cur_col);
            r_fwd_up  <= line_mid;
            r_fwd_mid <= r_f1_pix;
        end
        if (f1_adv) begin
            for (int k = 0; k < 3; k++) begin
                r_w1[k] <= r_f1_c0 ? '0 : r_w2[k];
                r_w2[k] <= new_col[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_push_item.px[k*3+0] = (r_f1_mask[1] && ((k != 0) || r_f1_mask[3])
                                     && ((k != 2) || r_f1_mask[2])) ? r_w1[k] : '0;
            o_push_item.px[k*3+1] = (((k != 0) || r_f1_mask[3])
                                     && ((k != 2) || r_f1_mask[2])) ? r_w2[k] : '0;
            o_push_item.px[k*3+2] = (r_f1_mask[0] && ((k != 0) || r_f1_mask[3])
                                     && ((k != 2) || r_f1_mask[2])) ? new_col[k] : '0;
        end
        o_push_item.last = r_f1_last;
    end

    assign o_push = f1_adv && r_f1_emit;

endmodule

>>> hdl/sobm_fifo.sv
module sobm_fifo
    import sobm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_win_item i_item,
    input  logic      i_pop,
    output t_win_item o_item,
    output logic      o_empty,
    output logic      o_full
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_win_item        r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

>>> hdl/sobm_back.sv
module sobm_back
    import sobm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  t_win_item       i_item,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [CH_W-1:0] o_red_out,
    output logic [CH_W-1:0] o_green_out,
    output logic [CH_W-1:0] o_blue_out,
    output logic            o_frame_last
);

    typedef struct packed {
        logic [CH_W-1:0] root;
        logic [17:0]     rem;
    } t_sq;

    // one digit of the shift-subtract square root
    function automatic t_sq sq_step(t_sq x, int i);
        logic [17:0] trial;
        t_sq         y;
        trial = (18'(x.root) << (i + 1)) + (18'd1 << (2 * i));
        y     = x;
        if (x.rem >= trial) begin
            y.rem  = x.rem - trial;
            y.root = x.root | (CH_W'(1) << i);
        end
        return y;
    endfunction

    logic en;

    logic              r_b1_v, r_b2_v, r_b3_v, r_out_v;
    logic              r_b1_last, r_b2_last, r_b3_last, r_out_last;
    logic signed [10:0] r_gx [3];
    logic signed [10:0] r_gy [3];
    logic [15:0]       r_m   [3];
    logic              r_sat [3];
    logic              r_sat3 [3];
    t_sq               r_sq  [3];
    logic [CH_W-1:0]   r_res [3];

    logic signed [10:0] gx [3];
    logic signed [10:0] gy [3];
    logic [20:0]        m  [3];
    t_sq                sq_a [3];
    t_sq                sq_b [3];
    logic [CH_W:0]      rnd [3];

    assign en    = !r_out_v || i_out_ready;
    assign o_pop = en && !i_empty;

    always_comb begin
        logic [CH_W-1:0] v [9];
        logic [9:0]      xp, xn, yp, yn;
        logic signed [21:0] px2, py2;
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 9; k++) begin
                v[k] = i_item.px[k][ch*CH_W +: CH_W];
            end
            xp = 10'(v[2]) + {1'b0, v[5], 1'b0} + 10'(v[8]);
            xn = 10'(v[0]) + {1'b0, v[3], 1'b0} + 10'(v[6]);
            yp = 10'(v[6]) + {1'b0, v[7], 1'b0} + 10'(v[8]);
            yn = 10'(v[0]) + {1'b0, v[1], 1'b0} + 10'(v[2]);
            gx[ch] = signed'({1'b0, xp}) - signed'({1'b0, xn});
            gy[ch] = signed'({1'b0, yp}) - signed'({1'b0, yn});
            px2    = r_gx[ch] * r_gx[ch];
            py2    = r_gy[ch] * r_gy[ch];
            m[ch]  = px2[20:0] + py2[20:0];
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            sq_a[ch].root = '0;
            sq_a[ch].rem  = 18'(r_m[ch]);
            for (int i = 7; i >= 4; i--) begin
                sq_a[ch] = sq_step(sq_a[ch], i);
            end
            sq_b[ch] = r_sq[ch];
            for (int i = 3; i >= 0; i--) begin
                sq_b[ch] = sq_step(sq_b[ch], i);
            end
            // round half: remainder above root means the upper neighbor is closer
            rnd[ch] = (sq_b[ch].rem > 18'(sq_b[ch].root))
                ? (CH_W + 1)'(sq_b[ch].root) + (CH_W + 1)'(1)
                : (CH_W + 1)'(sq_b[ch].root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_b2_v  <= 1'b0;
            r_b3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_b1_v  <= !i_empty;
            r_b2_v  <= r_b1_v;
            r_b3_v  <= r_b2_v;
            r_out_v <= r_b3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_last  <= i_item.last;
            r_b2_last  <= r_b1_last;
            r_b3_last  <= r_b2_last;
            r_out_last <= r_b3_last;
            for (int ch = 0; ch < 3; ch++) begin
                r_gx[ch]   <= gx[ch];
                r_gy[ch]   <= gy[ch];
                r_sat[ch]  <= (m[ch] > 21'd65280);
                r_m[ch]    <= m[ch][15:0];
                r_sat3[ch] <= r_sat[ch];
                r_sq[ch]   <= sq_a[ch];
                r_res[ch]  <= (r_sat3[ch] || rnd[ch][CH_W]) ? '1 : rnd[ch][CH_W-1:0];
            end
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_red_out    = r_res[2];
    assign o_green_out  = r_res[1];
    assign o_blue_out   = r_res[0];
    assign o_frame_last = r_out_last;

endmodule

>>> hdl/sobm_checker.sv
module sobm_checker
    import sobm_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input logic [CH_W-1:0] o_red_out,
    input logic [CH_W-1:0] o_green_out,
    input logic [CH_W-1:0] o_blue_out,
    input logic            o_frame_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable({o_red_out, o_green_out, o_blue_out, o_frame_last}))
        else $error("result transaction changed while stalled");

    a_rst_no_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> o_in_ready)
        else $error("input not ready right after reset");

endmodule

bind sobel_edge_magnitude_rgb_unit sobm_checker u_sobm_checker (.*);
